// File: sv/block_average_downsampler_core_assert.svh
// ----------------------------------------------------------------------------
// Block average downsampler assertion macros
// Clocked property checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DOWNSAMPLER_CORE_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSAMPLER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define BADS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("block_average_downsampler_core: assertion failed");
// Next-cycle implication.
`define BADS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("block_average_downsampler_core: assertion failed");
`else
`define BADS_ASSERT_IMP(lbl, ante, cons)
`define BADS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/bads_pkg.sv
// ----------------------------------------------------------------------------
// Block average downsampler package
// Shared payload types, job descriptors and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bads_pkg;

   // A list holds at most 64 samples, so a length needs 7 bits.
   localparam int LEN_W       = 7;
   localparam int FACTOR_W    = 7;
   localparam int VALUE_W     = 16;
   localparam int ACC_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE = 2'd1;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 7'd1;
   localparam logic [VALUE_W-1:0]  MAX_VALUE_RESET = 16'hFFFF;

   typedef struct packed {
      logic [15:0] sample;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [15:0] average;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             bank;
   } job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/bads_store.sv
// ----------------------------------------------------------------------------
// Block average downsampler sample store
// Two banks of sample memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bads_store #(
   parameter int MAX_SAMPLES = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_SAMPLES):0]       wr_addr,
   input  logic [SAMPLE_BITS-1:0]             wr_data,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_SAMPLES):0]       rd_addr,
   output logic [SAMPLE_BITS-1:0]             rd_data
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int DEPTH = 2 ** (AW + 1);

   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bads_front.sv
// ----------------------------------------------------------------------------
// Block average downsampler front end
// Loads samples into the free bank and hands each finished list to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bads_front import bads_pkg::*; #(
   parameter int MAX_SAMPLES = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  req_type                      req_data,
   output logic                         busy,
   output logic                         wr_en,
   output logic [$clog2(MAX_SAMPLES):0] wr_addr,
   output logic [SAMPLE_BITS-1:0]       wr_data,
   output logic                         push,
   output job_type                      push_job,
   input  done_type                     done
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             bank_ff, bank_in;
   logic [1:0]       bank_busy_ff, bank_busy_in;
   logic             accept;
   logic             room;
   logic [CNT_W-1:0] count_next;

   assign busy   = bank_busy_ff[bank_ff];
   assign accept = start && !busy;
   assign room   = count_ff < CNT_MAX;

   assign count_next = room ? count_ff + CNT_W'(1) : count_ff;

   // Samples past the capacity are dropped; a marked one still closes the list.
   assign wr_en   = accept && room;
   assign wr_addr = {bank_ff, count_ff[AW-1:0]};
   assign wr_data = SAMPLE_BITS'(req_data.sample);

   assign push          = accept && req_data.last_in;
   assign push_job.len  = LEN_W'(count_next);
   assign push_job.bank = bank_ff;

   always_comb begin
      count_in     = count_ff;
      bank_in      = bank_ff;
      bank_busy_in = bank_busy_ff;
      if (done.valid) begin
         bank_busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         if (req_data.last_in) begin
            count_in              = '0;
            bank_in               = !bank_ff;
            bank_busy_in[bank_ff] = 1'b1;
         end else begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         bank_busy_ff <= '0;
      end else begin
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         bank_busy_ff <= bank_busy_in;
      end
   end

endmodule

// File: sv/bads_job_queue.sv
// ----------------------------------------------------------------------------
// Block average downsampler job queue
// Two-entry queue of finished lists between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bads_job_queue import bads_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head,
   output qstat_type stat
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = count_ff == 2'd2;
   assign stat.empty = count_ff == 2'd0;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// File: sv/bads_div.sv
// ----------------------------------------------------------------------------
// Block average downsampler divider
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bads_div import bads_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ACC_W-1:0]    dividend,
   input  logic [FACTOR_W-1:0] divisor,
   output logic                done,
   output logic [ACC_W-1:0]    quotient
);

   localparam int SW = $clog2(ACC_W);
   localparam logic [SW-1:0] STEP_LAST = SW'(ACC_W - 1);

   logic                run_ff;
   logic [SW-1:0]       step_ff;
   logic [FACTOR_W:0]   rem_ff;
   logic [ACC_W-1:0]    quo_ff;
   logic [FACTOR_W-1:0] dsr_ff;
   logic                done_ff;
   logic [FACTOR_W:0]   rem_shift;
   logic                fits;

   assign rem_shift = {rem_ff[FACTOR_W-1:0], quo_ff[ACC_W-1]};
   assign fits      = rem_shift >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? rem_shift - {1'b0, dsr_ff} : rem_shift;
         quo_ff <= {quo_ff[ACC_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + SW'(1);
            if (step_ff == STEP_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/bads_back.sv
// ----------------------------------------------------------------------------
// Block average downsampler back end
// Takes one list at a time, passes it through or sums and divides its buckets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bads_back import bads_pkg::*; #(
   parameter int MAX_SAMPLES = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qstat_type                    q_stat,
   input  job_type                      head,
   output logic                         pop,
   input  logic [FACTOR_W-1:0]          factor,
   input  logic [VALUE_W-1:0]           max_value,
   output logic                         rd_en,
   output logic [$clog2(MAX_SAMPLES):0] rd_addr,
   input  logic [SAMPLE_BITS-1:0]       rd_data,
   output logic                         div_start,
   output logic [ACC_W-1:0]             div_dividend,
   output logic [FACTOR_W-1:0]          div_divisor,
   input  logic                         div_done,
   input  logic [ACC_W-1:0]             div_quotient,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data,
   output done_type                     done
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam logic [63:0] MASK64 = (64'd1 << SAMPLE_BITS) - 64'd1;
   localparam logic [ACC_W-1:0] SMASK = MASK64[ACC_W-1:0];

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASSIFY, ST_CNT_GO, ST_CNT_WAIT, ST_PT_RD, ST_PT_OUT,
      ST_SUM_RD, ST_SUM_ACC, ST_AVG_GO, ST_AVG_WAIT
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                bank_ff, bank_in;
   logic [FACTOR_W-1:0] f_ff, f_in;
   logic [FACTOR_W-1:0] b_ff, b_in;
   logic [LEN_W-1:0]    nb_ff, nb_in;
   logic [LEN_W-1:0]    bucket_ff, bucket_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   done_type            done_ff, done_in;

   logic [LEN_W-1:0]    d_quo;
   logic                last_bkt;
   logic [LEN_W-1:0]    idx_nx;
   logic [LEN_W-1:0]    cnt_nx;
   logic [ACC_W-1:0]    avg;

   assign d_quo    = div_quotient[LEN_W-1:0];
   assign last_bkt = bucket_ff == nb_ff - LEN_W'(1);
   assign idx_nx   = idx_ff + LEN_W'(1);
   assign cnt_nx   = cnt_ff + LEN_W'(1);

   // Only the final bucket is clamped.
   assign avg = (last_bkt && div_quotient > ACC_W'(max_value)) ? ACC_W'(max_value)
                                                               : div_quotient;

   assign pop          = state_ff == ST_IDLE && !q_stat.empty;
   assign rd_en        = state_ff == ST_PT_RD || state_ff == ST_SUM_RD;
   assign rd_addr      = {bank_ff, idx_ff[AW-1:0]};
   assign div_start    = state_ff == ST_CNT_GO || state_ff == ST_AVG_GO;
   assign div_dividend = (state_ff == ST_CNT_GO) ? ACC_W'(len_ff) : acc_ff;
   assign div_divisor  = (state_ff == ST_CNT_GO) ? f_ff : b_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      bank_in      = bank_ff;
      f_in         = f_ff;
      b_in         = b_ff;
      nb_in        = nb_ff;
      bucket_in    = bucket_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      done_in      = '{valid: 1'b0, bank: bank_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               len_in   = head.len;
               bank_in  = head.bank;
               f_in     = (factor == '0) ? FACTOR_W'(1) : factor;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            idx_in = '0;
            if (LEN_W'(f_ff) >= len_ff) begin
               state_in = ST_PT_RD;
            end else begin
               state_in = ST_CNT_GO;
            end
         end
         ST_CNT_GO: begin
            state_in = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: begin
            if (div_done) begin
               // More samples per bucket than buckets: the two trade places.
               if (LEN_W'(f_ff) > d_quo) begin
                  b_in  = FACTOR_W'(d_quo);
                  nb_in = LEN_W'(f_ff);
               end else begin
                  b_in  = f_ff;
                  nb_in = d_quo;
               end
               idx_in    = '0;
               cnt_in    = '0;
               bucket_in = '0;
               acc_in    = '0;
               state_in  = ST_SUM_RD;
            end
         end
         ST_PT_RD: begin
            state_in = ST_PT_OUT;
         end
         ST_PT_OUT: begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.average  = VALUE_W'(rd_data);
            rsp_data_in.last_out = idx_nx == len_ff;
            idx_in               = idx_nx;
            if (idx_nx == len_ff) begin
               done_in.valid = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_PT_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            acc_in = acc_ff + ACC_W'(rd_data);
            idx_in = idx_nx;
            cnt_in = cnt_nx;
            // The final bucket runs to the end of the list and takes the remainder.
            if (last_bkt ? (idx_nx == len_ff) : (cnt_nx == LEN_W'(b_ff))) begin
               state_in = ST_AVG_GO;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_AVG_GO: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.average  = VALUE_W'(avg & SMASK);
               rsp_data_in.last_out = last_bkt;
               if (last_bkt) begin
                  done_in.valid = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  bucket_in = bucket_ff + LEN_W'(1);
                  cnt_in    = '0;
                  acc_in    = '0;
                  state_in  = ST_SUM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
      len_ff      <= len_in;
      bank_ff     <= bank_in;
      f_ff        <= f_in;
      b_ff        <= b_in;
      nb_ff       <= nb_in;
      bucket_ff   <= bucket_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign done      = done_ff;

endmodule

// File: sv/block_average_downsampler_core.sv
// ----------------------------------------------------------------------------
// Block average downsampler core
// Collects a list of samples and emits its block-averaged copy.
// ----------------------------------------------------------------------------
// Samples enter one per cycle while busy is low; the item that carries
// last_in closes the list. A list no longer than the factor comes back
// unchanged; otherwise it is cut into buckets, and each bucket sum divided by
// the bucket size is emitted, the final bucket also taking the remainder and
// being clamped to max_value. Results appear on rsp_data for exactly one cycle
// under rsp_valid and cannot be held off, so the receiver must take every
// result as it comes. The sample store has two banks, so the next list can
// load while the previous one is processed; busy rises only when both banks
// hold lists not yet finished. Processing a list takes a store read and an
// add per sample (a read and an output when passed through), plus a division
// per bucket and another for the bucket count, on the shared one-bit-per-cycle
// divider. Write factor and max_value only while no list is loading or being
// processed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_average_downsampler_core_assert.svh"

module block_average_downsampler_core import bads_pkg::*; #(
   parameter int MAX_SAMPLES = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);

   // Configuration registers. Writes to unknown indexes are ignored.
   logic [FACTOR_W-1:0] factor_ff;
   logic [VALUE_W-1:0]  max_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_RESET;
         max_value_ff <= MAX_VALUE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_FACTOR) begin
            factor_ff <= csr_wdata[FACTOR_W-1:0];
         end
         if (csr_index == CSR_MAX_VALUE) begin
            max_value_ff <= csr_wdata[VALUE_W-1:0];
         end
      end
   end

   // Store ports, queue handshake and divider wiring.
   logic                   wr_en;
   logic [AW:0]            wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [AW:0]            rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic                   job_push;
   job_type                push_job;
   logic                   job_pop;
   job_type                head_job;
   qstat_type              q_stat;
   done_type               job_done;
   logic                   div_start;
   logic [ACC_W-1:0]       div_dividend;
   logic [FACTOR_W-1:0]    div_divisor;
   logic                   div_done;
   logic [ACC_W-1:0]       div_quotient;

   // The front end fills one bank while the back end drains the other.
   bads_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .push     (job_push),
      .push_job (push_job),
      .done     (job_done)
   );

   bads_store #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Each queued job names a closed list: its length and its bank.
   bads_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head     (head_job),
      .stat     (q_stat)
   );

   // One divider serves both the bucket count and every bucket average.
   bads_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   bads_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .head         (head_job),
      .pop          (job_pop),
      .factor       (factor_ff),
      .max_value    (max_value_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .done         (job_done)
   );

   // Two banks bound the outstanding lists, so the queue never overflows.
   `BADS_ASSERT_IMP(a_queue_no_overflow, job_push, !q_stat.full || job_pop)
   // The back end only takes a job that is there.
   `BADS_ASSERT_IMP(a_queue_no_underflow, job_pop, !q_stat.empty)
   // After the final value of a run, the back end must go back for a new job.
   `BADS_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_data.last_out, !rsp_valid)

endmodule
